>>> rtl/core/sha1mh_pkg.sv
package sha1mh_pkg;

  localparam int WORD_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int FILL_W   = 6;
  localparam int LEN_W    = 64;
  localparam int ROUND_W  = 7;
  localparam int IDX_W    = 3;
  localparam int CHAIN_N  = 5;
  localparam int SCHED_N  = 16;

  localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'd79;
  localparam logic [ROUND_W-1:0] ROUND_SCHED = 7'd16;
  localparam logic [ROUND_W-1:0] ROUND_R2    = 7'd20;
  localparam logic [ROUND_W-1:0] ROUND_R3    = 7'd40;
  localparam logic [ROUND_W-1:0] ROUND_R4    = 7'd60;

  localparam logic [FILL_W-1:0] FILL_LEN_POS = 6'd56;
  localparam logic [FILL_W-1:0] FILL_LAST    = 6'd63;
  localparam logic [IDX_W-1:0]  IDX_LAST     = 3'd4;
  localparam logic [BYTE_W-1:0] PAD_BYTE     = 8'h80;
  localparam logic [LEN_W-1:0]  BITS_PER_BYTE = 64'd8;

  localparam logic [WORD_W-1:0] INIT_H [CHAIN_N] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K_R1 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_R2 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_R3 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_R4 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  // Where the message stands: taking bytes, or which part of the padding is next.
  typedef enum logic [2:0] {
    PH_MSG,
    PH_80,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } phase_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
    rotl = (v << s) | (v >> (WORD_W - s));
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] r);
    if (r < ROUND_R2) begin
      round_k = K_R1;
    end else if (r < ROUND_R3) begin
      round_k = K_R2;
    end else if (r < ROUND_R4) begin
      round_k = K_R3;
    end else begin
      round_k = K_R4;
    end
  endfunction

  function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] r,
                                               input logic [WORD_W-1:0] b,
                                               input logic [WORD_W-1:0] c,
                                               input logic [WORD_W-1:0] d);
    if (r < ROUND_R2) begin
      round_f = (b & c) | (~b & d);
    end else if (r < ROUND_R3) begin
      round_f = b ^ c ^ d;
    end else if (r < ROUND_R4) begin
      round_f = (b & c) | (b & d) | (c & d);
    end else begin
      round_f = b ^ c ^ d;
    end
  endfunction

endpackage

>>> rtl/core/sha1mh_msg_if.sv
interface sha1mh_msg_if;
  logic                          valid;
  logic                          ready;
  logic [sha1mh_pkg::BYTE_W-1:0] data_byte;
  logic                          has_byte;
  logic                          end_of_message;

  modport source(output valid, output data_byte, output has_byte, output end_of_message,
                 input ready);
  modport sink(input valid, input data_byte, input has_byte, input end_of_message,
               output ready);
endinterface

>>> rtl/core/sha1mh_dig_if.sv
interface sha1mh_dig_if;
  logic                          valid;
  logic                          ready;
  logic [sha1mh_pkg::WORD_W-1:0] digest_word;
  logic [sha1mh_pkg::IDX_W-1:0]  word_index;
  logic                          last_word;

  modport source(output valid, output digest_word, output word_index, output last_word,
                 input ready);
  modport sink(input valid, input digest_word, input word_index, input last_word,
               output ready);
endinterface

>>> rtl/core/sha1_message_hasher_top.sv
// A message word is taken while the block is idle; every 64th byte then holds off input
// for the 80 rounds of the single round unit, one per cycle, and the fold step.
// An end-of-message word adds the padding bytes plus one or two compressions,
// then the five digest words leave one per cycle as the sink takes them.
// Synchronous reset returns the chain to the initial hash and clears length and fill.
module sha1_message_hasher_top (
  input  logic         clk,
  input  logic         rst,
  sha1mh_msg_if.sink   msg,
  sha1mh_dig_if.source dig
);
  import sha1mh_pkg::*;

  state_t state;
  state_t state_next;
  phase_t phase;
  phase_t phase_next;

  logic [WORD_W-1:0]  chain [CHAIN_N];
  logic [WORD_W-1:0]  sched [SCHED_N];
  logic [23:0]        word_acc;
  logic [FILL_W-1:0]  fill_count;
  logic [LEN_W-1:0]   bit_length;
  logic [WORD_W-1:0]  va, vb, vc, vd, ve;
  logic [ROUND_W-1:0] round_count;
  logic [IDX_W-1:0]   emit_idx;

  logic               msg_acc;
  logic               dig_acc;
  logic               put_en;
  logic [BYTE_W-1:0]  put_data;
  logic               len_shift;
  logic               block_full;
  logic               shift_en;
  logic [WORD_W-1:0]  shift_in;
  logic [WORD_W-1:0]  wt;
  logic [WORD_W-1:0]  t;

  assign msg_acc    = msg.valid && msg.ready;
  assign dig_acc    = dig.valid && dig.ready;
  assign block_full = put_en && (fill_count == FILL_LAST);

  // Byte insertion: message bytes while idle, padding and length bytes in S_PAD.
  always_comb begin
    put_en     = 1'b0;
    put_data   = msg.data_byte;
    len_shift  = 1'b0;
    phase_next = phase;
    case (state)
      S_IDLE: begin
        if (msg_acc && msg.has_byte) begin
          put_en = 1'b1;
        end
        if (msg_acc && msg.end_of_message) begin
          phase_next = PH_80;
        end
      end
      S_PAD: begin
        case (phase)
          PH_80: begin
            put_en     = 1'b1;
            put_data   = PAD_BYTE;
            phase_next = PH_ZERO;
          end
          PH_ZERO: begin
            put_en = 1'b1;
            if (fill_count == FILL_LEN_POS) begin
              put_data   = bit_length[LEN_W-1 -: BYTE_W];
              len_shift  = 1'b1;
              phase_next = PH_LEN;
            end else begin
              put_data = '0;
            end
          end
          PH_LEN: begin
            put_en    = 1'b1;
            put_data  = bit_length[LEN_W-1 -: BYTE_W];
            len_shift = 1'b1;
            if (fill_count == FILL_LAST) begin
              phase_next = PH_DONE;
            end
          end
          default: begin
            put_en = 1'b0;
          end
        endcase
      end
      S_EMIT: begin
        if (dig_acc && (emit_idx == IDX_LAST)) begin
          phase_next = PH_MSG;
        end
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  // The schedule line holds the last 16 words, oldest at index 0.
  assign wt = (round_count < ROUND_SCHED) ? sched[0]
            : rotl(sched[13] ^ sched[8] ^ sched[2] ^ sched[0], 1);
  assign t  = rotl(va, 5) + round_f(round_count, vb, vc, vd) + ve + round_k(round_count) + wt;

  assign shift_en = (state == S_ROUND) || (put_en && (fill_count[1:0] == 2'd3));
  assign shift_in = (state == S_ROUND) ? wt : {word_acc, put_data};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (msg_acc) begin
          if (block_full) begin
            state_next = S_ROUND;
          end else if (msg.end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (block_full) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (round_count == ROUND_LAST) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        case (phase)
          PH_MSG:  state_next = S_IDLE;
          PH_DONE: state_next = S_EMIT;
          default: state_next = S_PAD;
        endcase
      end
      S_EMIT: begin
        if (dig_acc && (emit_idx == IDX_LAST)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    msg.ready       = (state == S_IDLE);
    dig.valid       = (state == S_EMIT);
    dig.digest_word = chain[emit_idx];
    dig.word_index  = emit_idx;
    dig.last_word   = (emit_idx == IDX_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_MSG;
      fill_count  <= '0;
      bit_length  <= '0;
      round_count <= '0;
      emit_idx    <= '0;
      for (int i = 0; i < CHAIN_N; i++) begin
        chain[i] <= INIT_H[i];
      end
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (put_en) begin
        fill_count <= fill_count + 1'b1;
      end
      if ((state == S_IDLE) && put_en) begin
        bit_length <= bit_length + BITS_PER_BYTE;
      end else if (len_shift) begin
        bit_length <= bit_length << BYTE_W;
      end
      if (state == S_ROUND) begin
        round_count <= (round_count == ROUND_LAST) ? '0 : round_count + 1'b1;
      end
      if (state == S_FOLD) begin
        chain[0] <= chain[0] + va;
        chain[1] <= chain[1] + vb;
        chain[2] <= chain[2] + vc;
        chain[3] <= chain[3] + vd;
        chain[4] <= chain[4] + ve;
      end
      if (dig_acc) begin
        if (emit_idx == IDX_LAST) begin
          emit_idx   <= '0;
          bit_length <= '0;
          for (int i = 0; i < CHAIN_N; i++) begin
            chain[i] <= INIT_H[i];
          end
        end else begin
          emit_idx <= emit_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_en && (fill_count[1:0] != 2'd3)) begin
      word_acc <= {word_acc[15:0], put_data};
    end
    if (shift_en) begin
      for (int i = 0; i < SCHED_N - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[SCHED_N-1] <= shift_in;
    end
    if (block_full) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (state == S_ROUND) begin
      ve <= vd;
      vd <= vc;
      vc <= rotl(vb, 30);
      vb <= va;
      va <= t;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && dig.valid))
    else $error("input taken while digest words are pending");

  a_fold_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FOLD) |-> ($past(state) == S_ROUND) && (round_count == '0))
    else $error("fold without a full set of rounds");

  a_emit_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (phase == PH_DONE) && (fill_count == '0))
    else $error("digest emitted before padding completed");

  a_restart_clean: assert property (@(posedge clk) disable iff (rst)
    (dig_acc && dig.last_word) |=>
      (state == S_IDLE) && (bit_length == '0) && (fill_count == '0) && (phase == PH_MSG))
    else $error("state not returned to start after digest");

  a_len_frozen: assert property (@(posedge clk) disable iff (rst)
    ((state == S_ROUND) || (state == S_FOLD)) |=> $stable(bit_length))
    else $error("length changed during compression");

endmodule

>>> tb/sha1_digest_checker.sv
`timescale 1ns / 1ps

module sha1_digest_checker (
  input  logic  clk,
  input  logic  rst,
  sha1mh_msg_if msg,
  sha1mh_dig_if dig,
  output int    fails,
  output int    pending
);
  import sha1mh_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  word_idx;
    logic              last;
  } digest_res_t;

  logic [WORD_W-1:0] chain_h [CHAIN_N];
  logic [WORD_W-1:0] block_w [SCHED_N];
  logic [FILL_W-1:0] fill_cnt;
  logic [LEN_W-1:0]  msg_bits;
  digest_res_t       digest_q [$];

  function automatic void restart_digest();
    for (int i = 0; i < CHAIN_N; i++) begin
      chain_h[i] = INIT_H[i];
    end
    fill_cnt = '0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [WORD_W-1:0] w [SCHED_N];
    logic [WORD_W-1:0] a, b, c, d, e, f, k, wt, t;
    w = block_w;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        wt = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
        wt = {wt[30:0], wt[31]};
        w[r % 16] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_R1;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_R2;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R3;
      end else begin
        f = b ^ c ^ d;
        k = K_R4;
      end
      t = {a[26:0], a[31:27]} + f + e + k + wt;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Bytes land big-endian: the first byte of each word goes to bits 31:24.
  function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
    int sh;
    sh = 8 * (3 - int'(fill_cnt[1:0]));
    block_w[fill_cnt[5:2]][sh +: 8] = b;
    fill_cnt = fill_cnt + 1'b1;
    if (fill_cnt == '0) begin
      compress_block();
    end
  endfunction

  function automatic void finish_message();
    logic [LEN_W-1:0] len;
    digest_res_t      res;
    len = msg_bits;
    absorb_byte(PAD_BYTE);
    while (fill_cnt != FILL_LEN_POS) begin
      absorb_byte('0);
    end
    for (int i = 7; i >= 0; i--) begin
      absorb_byte(len[8*i +: 8]);
    end
    for (int i = 0; i < CHAIN_N; i++) begin
      res.word     = chain_h[i];
      res.word_idx = IDX_W'(i);
      res.last     = (i == CHAIN_N - 1);
      digest_q.push_back(res);
    end
    restart_digest();
  endfunction

  always @(posedge clk) begin
    digest_res_t got, exp;
    if (rst) begin
      restart_digest();
      digest_q.delete();
      fails = 0;
    end else begin
      if (msg.valid && msg.ready) begin
        if (msg.has_byte) begin
          absorb_byte(msg.data_byte);
          msg_bits += BITS_PER_BYTE;
        end
        if (msg.end_of_message) begin
          finish_message();
        end
      end
      if (dig.valid && dig.ready) begin
        got = '{dig.digest_word, dig.word_index, dig.last_word};
        if (digest_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: digest word %h idx %0d last %0b arrived with none expected",
                     $realtime, got.word, got.word_idx, got.last);
          end
        end else begin
          exp = digest_q.pop_front();
          if (got.word !== exp.word || got.word_idx !== exp.word_idx ||
              got.last !== exp.last) begin
            fails++;
            if (fails <= 10) begin
              $display({"%0t: digest mismatch: expected %h idx %0d last %0b, ",
                        "got %h idx %0d last %0b"},
                       $realtime, exp.word, exp.word_idx, exp.last,
                       got.word, got.word_idx, got.last);
            end
          end
        end
      end
    end
    pending = digest_q.size();
  end

endmodule

>>> tb/sha1_message_hasher_top_tb.sv
`timescale 1ns / 1ps

module sha1_message_hasher_top_tb;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   send_idle_pct;
  int   stall_pct;
  int   msg_items;

  sha1mh_msg_if msg_if();
  sha1mh_dig_if dig_if();

  sha1_message_hasher_top u_top (
    .clk (clk),
    .rst (rst),
    .msg (msg_if),
    .dig (dig_if)
  );

  sha1_digest_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg_if),
    .dig     (dig_if),
    .fails   (fails),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    dig_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      dig_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Valid is only lowered when an idle cycle is chosen, so back-to-back words keep it high.
  task automatic send_word(input logic [7:0] b, input logic hb, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_if.valid = 1'b0;
      @(negedge clk);
    end
    msg_if.valid          = 1'b1;
    msg_if.data_byte      = b;
    msg_if.has_byte       = hb;
    msg_if.end_of_message = eom;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(input int nbytes, input bit byte_in_end, input int noise_pct);
    bit ends_here;
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_word(8'($urandom_range(255)), 1'b0, 1'b0);
        msg_items++;
      end
      ends_here = byte_in_end && (i == nbytes - 1);
      send_word(8'($urandom_range(255)), 1'b1, ends_here);
      msg_items++;
    end
    if (!(byte_in_end && nbytes > 0)) begin
      send_word(8'($urandom_range(255)), 1'b0, 1'b1);
      msg_items++;
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int msg_no;
    int pick;
    int nbytes;
    rst                   = 1'b1;
    send_idle_pct         = 0;
    stall_pct             = 0;
    msg_items             = 0;
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = '0;
    msg_if.has_byte       = 1'b0;
    msg_if.end_of_message = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Words with neither flag set must be ignored, whatever the data.
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    // Empty message, with stray data bits on the end word.
    send_word(8'hFF, 1'b0, 1'b1);
    // "abc" with its last byte carried by the end word.
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    // Extreme bytes followed by a separate end word.
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'hAA, 1'b0, 1'b1);
    // One-byte message in the end word, then another empty message.
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
    msg_items = 12;
    msg_if.valid = 1'b0;
    wait_drained();

    // Lengths cluster around 52..66 bytes, where padding needs one or two final blocks.
    msg_no = 0;
    while (msg_items < 200 || msg_no < 4) begin
      case (msg_no % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 68;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 68;
        end
        default: begin
          send_idle_pct = 18;
          stall_pct     = 18;
        end
      endcase
      pick = $urandom_range(99);
      if (pick < 40) begin
        nbytes = $urandom_range(8);
      end else if (pick < 80) begin
        nbytes = $urandom_range(66, 52);
      end else begin
        nbytes = $urandom_range(130);
      end
      send_message(nbytes, $urandom_range(1), 8);
      msg_no++;
      if (msg_no == 2) begin
        msg_if.valid = 1'b0;
        wait_drained();
      end
    end
    msg_if.valid = 1'b0;

    wait_drained();
    repeat (20) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sha1mh_pkg.sv
rtl/core/sha1mh_msg_if.sv
rtl/core/sha1mh_dig_if.sv
rtl/core/sha1_message_hasher_top.sv
tb/sha1_digest_checker.sv
tb/sha1_message_hasher_top_tb.sv
